/* rtl/core/psbp_pkg.sv */
// Shared types and constants of the paged stream bank packer.
`timescale 1ns / 1ps
`default_nettype none
package psbp_pkg;

   localparam int BYTE_W   = 8;
   localparam int BANK_W   = 7;
   localparam int OFFSET_W = 13;
   localparam int FILL_W   = 14;
   localparam int ADDR_W   = 16;
   localparam int STATUS_W = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam int BANK_CAP = 127;

   localparam logic [BYTE_W-1:0] SHORT_EVENT_MIN = 8'hFE;
   localparam logic [BYTE_W-1:0] MARK_JUMP       = 8'hFB;
   localparam logic [BYTE_W-1:0] MARK_CONTINUE   = 8'hFD;

   localparam logic [FILL_W-1:0] HOLE_START = 14'h1800;
   localparam logic [FILL_W-1:0] HOLE_END   = 14'h1900;
   localparam logic [FILL_W:0]   JUMP_GUARD = {1'b0, HOLE_START} - (FILL_W + 1)'(3);

   localparam logic [ADDR_W-1:0] WINDOW_BASE = 16'h8000;
   localparam logic [ADDR_W-1:0] JUMP_TARGET = WINDOW_BASE + {2'b00, HOLE_END};

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_OUT_OF_BANKS,
      STATUS_MID_EVENT,
      STATUS_HALTED
   } status_type;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_EVENT,
      CMD_FAIL
   } cmd_kind_type;

   typedef struct packed {
      logic              want_ref;
      cmd_kind_type      kind;
      logic              two_byte;
      logic [BYTE_W-1:0] byte0;
      logic [BYTE_W-1:0] byte1;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } queue_wr_type;

   typedef struct packed {
      logic    valid;
      logic    full;
      cmd_type cmd;
   } queue_rd_type;

   typedef enum logic [2:0] {
      ST_HEAD,
      ST_ROOM,
      ST_BYTE1,
      ST_JUMP1,
      ST_JUMP2,
      ST_CONT1,
      ST_FAIL
   } back_state_type;

   typedef struct packed {
      logic                write_valid;
      logic [BANK_W-1:0]   bank_index;
      logic [OFFSET_W-1:0] byte_offset;
      logic [BYTE_W-1:0]   byte_value;
      logic                ref_valid;
      logic [BANK_W-1:0]   ref_bank_number;
      logic [ADDR_W-1:0]   ref_window_addr;
      logic [BANK_W-1:0]   banks_used;
      status_type          status;
      logic                last;
   } result_type;

endpackage
`default_nettype wire

/* rtl/core/psbp_req_if.sv */
// Stream byte channel carrying one input byte and its track flags.
`timescale 1ns / 1ps
`default_nettype none
interface psbp_req_if;
   logic                         valid;
   logic                         ready;
   logic [psbp_pkg::BYTE_W-1:0]  stream_byte;
   logic                         first_of_track;
   logic                         last_of_track;

   modport source (output valid, stream_byte, first_of_track, last_of_track, input ready);
   modport sink (input valid, stream_byte, first_of_track, last_of_track, output ready);
endinterface
`default_nettype wire

/* rtl/core/psbp_rsp_if.sv */
// Result channel carrying bank writes, track references and status.
`timescale 1ns / 1ps
`default_nettype none
interface psbp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          write_valid;
   logic [psbp_pkg::BANK_W-1:0]   bank_index;
   logic [psbp_pkg::OFFSET_W-1:0] byte_offset;
   logic [psbp_pkg::BYTE_W-1:0]   byte_value;
   logic                          ref_valid;
   logic [psbp_pkg::BANK_W-1:0]   ref_bank_number;
   logic [psbp_pkg::ADDR_W-1:0]   ref_window_addr;
   logic [psbp_pkg::BANK_W-1:0]   banks_used;
   logic [psbp_pkg::STATUS_W-1:0] status;
   logic                          last;

   modport source (output valid, write_valid, bank_index, byte_offset, byte_value, ref_valid,
                   ref_bank_number, ref_window_addr, banks_used, status, last,
                   input ready);
   modport sink (input valid, write_valid, bank_index, byte_offset, byte_value, ref_valid,
                 ref_bank_number, ref_window_addr, banks_used, status, last,
                 output ready);
endinterface
`default_nettype wire

/* rtl/core/psbp_front.sv */
// Front end: accepts stream bytes, pairs two-byte events and issues commands.
`timescale 1ns / 1ps
`default_nettype none
module psbp_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   psbp_req_if.sink                    req_ch,
   input  wire psbp_pkg::queue_rd_type queue_rd,
   output psbp_pkg::queue_wr_type      queue_wr
);

   logic                          pending_valid_ff;
   logic                          pending_valid_in;
   logic [psbp_pkg::BYTE_W-1:0]   pending_byte_ff;
   logic [psbp_pkg::BYTE_W-1:0]   pending_byte_in;
   logic                          transfer;
   psbp_pkg::cmd_type             cmd;

   assign req_ch.ready = !queue_rd.full;
   assign transfer     = req_ch.valid && req_ch.ready;

   always_comb begin
      cmd.want_ref     = req_ch.first_of_track;
      cmd.kind         = psbp_pkg::CMD_NONE;
      cmd.two_byte     = 1'b0;
      cmd.byte0        = req_ch.stream_byte;
      cmd.byte1        = '0;
      pending_valid_in = pending_valid_ff;
      pending_byte_in  = pending_byte_ff;
      if (pending_valid_ff && req_ch.first_of_track) begin
         cmd.want_ref     = 1'b0;
         cmd.kind         = psbp_pkg::CMD_FAIL;
         pending_valid_in = 1'b0;
      end else if (pending_valid_ff) begin
         cmd.kind         = psbp_pkg::CMD_EVENT;
         cmd.two_byte     = 1'b1;
         cmd.byte0        = pending_byte_ff;
         cmd.byte1        = req_ch.stream_byte;
         pending_valid_in = 1'b0;
      end else if (req_ch.stream_byte >= psbp_pkg::SHORT_EVENT_MIN) begin
         cmd.kind = psbp_pkg::CMD_EVENT;
      end else if (req_ch.last_of_track) begin
         cmd.kind = psbp_pkg::CMD_FAIL;
      end else begin
         pending_valid_in = 1'b1;
         pending_byte_in  = req_ch.stream_byte;
      end
   end

   assign queue_wr.push = transfer;
   assign queue_wr.cmd  = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_valid_ff <= 1'b0;
      end else if (transfer) begin
         pending_valid_ff <= pending_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (transfer) begin
         pending_byte_ff <= pending_byte_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/psbp_queue.sv */
// Command queue between the front end and the placement engine.
`timescale 1ns / 1ps
`default_nettype none
module psbp_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire psbp_pkg::queue_wr_type queue_wr,
   input  wire logic                   pop,
   output psbp_pkg::queue_rd_type      queue_rd
);

   psbp_pkg::cmd_type                entry_ff [psbp_pkg::QUEUE_DEPTH];
   logic [psbp_pkg::QUEUE_AW-1:0]    wr_ptr_ff;
   logic [psbp_pkg::QUEUE_AW-1:0]    rd_ptr_ff;
   logic [psbp_pkg::QUEUE_AW:0]      count_ff;
   logic [psbp_pkg::QUEUE_AW:0]      count_in;
   logic                             do_pop;

   assign queue_rd.valid = count_ff != '0;
   assign queue_rd.full  = count_ff == (psbp_pkg::QUEUE_AW + 1)'(psbp_pkg::QUEUE_DEPTH);
   assign queue_rd.cmd   = entry_ff[rd_ptr_ff];
   assign do_pop         = pop && queue_rd.valid;

   always_comb begin
      count_in = count_ff;
      if (queue_wr.push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !queue_wr.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (queue_wr.push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (queue_wr.push) begin
         entry_ff[wr_ptr_ff] <= queue_wr.cmd;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/psbp_back.sv */
// Placement engine: places events into banks, inserts markers and reports results.
`timescale 1ns / 1ps
`default_nettype none
module psbp_back #(
   parameter int BANK_BYTES     = 8192,
   parameter int MAX_BANK_COUNT = 127
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire psbp_pkg::queue_rd_type queue_rd,
   output logic                        pop,
   psbp_rsp_if.source                  rsp_ch
);

   localparam int BANK_LIMIT = (MAX_BANK_COUNT > psbp_pkg::BANK_CAP) ?
                               psbp_pkg::BANK_CAP : MAX_BANK_COUNT;
   localparam logic [psbp_pkg::BANK_W:0]  LIMIT_W    = (psbp_pkg::BANK_W + 1)'(BANK_LIMIT);
   localparam logic [psbp_pkg::FILL_W:0]  CONT_LIMIT = (psbp_pkg::FILL_W + 1)'(BANK_BYTES - 2);

   psbp_pkg::back_state_type        state_ff;
   psbp_pkg::back_state_type        state_in;
   logic                            phase_ref_ff;
   logic                            phase_ref_in;
   logic [psbp_pkg::BANK_W-1:0]     open_banks_ff;
   logic [psbp_pkg::BANK_W-1:0]     open_banks_in;
   logic [psbp_pkg::FILL_W-1:0]     fill_ff;
   logic [psbp_pkg::FILL_W-1:0]     fill_in;
   logic                            halted_ff;
   logic                            halted_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   psbp_pkg::result_type            rsp_ff;
   psbp_pkg::result_type            rsp_in;

   logic                            out_free;
   logic                            emit;
   psbp_pkg::result_type            res;
   logic [psbp_pkg::BANK_W-1:0]     ob_eff;
   logic [psbp_pkg::FILL_W-1:0]     f_base;
   logic [psbp_pkg::FILL_W-1:0]     f_eff;
   logic [psbp_pkg::FILL_W:0]       f_end;
   logic                            room_ref;
   logic                            size_two;
   logic                            jump_need;
   logic                            cont_need;
   logic                            no_bank;
   logic                            room_active;
   psbp_pkg::cmd_type               head;

   function automatic psbp_pkg::result_type write_res(
      input logic [psbp_pkg::BANK_W-1:0] ob,
      input logic [psbp_pkg::FILL_W-1:0] f,
      input logic [psbp_pkg::BYTE_W-1:0] value
   );
      psbp_pkg::result_type r;
      r             = '0;
      r.write_valid = 1'b1;
      r.bank_index  = ob - 1'b1;
      r.byte_offset = f[psbp_pkg::OFFSET_W-1:0];
      r.byte_value  = value;
      r.banks_used  = ob;
      r.status      = psbp_pkg::STATUS_OK;
      return r;
   endfunction

   function automatic psbp_pkg::result_type status_res(
      input logic [psbp_pkg::BANK_W-1:0] ob,
      input psbp_pkg::status_type        code
   );
      psbp_pkg::result_type r;
      r            = '0;
      r.banks_used = ob;
      r.status     = code;
      r.last       = 1'b1;
      return r;
   endfunction

   assign head     = queue_rd.cmd;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      ob_eff    = (open_banks_ff == '0) ? psbp_pkg::BANK_W'(1) : open_banks_ff;
      f_base    = (open_banks_ff == '0) ? '0 : fill_ff;
      f_eff     = (f_base >= psbp_pkg::HOLE_START && f_base < psbp_pkg::HOLE_END) ?
                  psbp_pkg::HOLE_END : f_base;
      room_ref  = (state_ff == psbp_pkg::ST_HEAD) ? head.want_ref : phase_ref_ff;
      size_two  = !room_ref && head.two_byte;
      f_end     = {1'b0, f_eff} + (size_two ? (psbp_pkg::FILL_W + 1)'(2) :
                                              (psbp_pkg::FILL_W + 1)'(1));
      jump_need = (f_eff < psbp_pkg::HOLE_START) && (f_end > psbp_pkg::JUMP_GUARD);
      cont_need = f_end > CONT_LIMIT;
      no_bank   = {1'b0, ob_eff} >= LIMIT_W;
      room_active = (state_ff == psbp_pkg::ST_ROOM) ||
                    (state_ff == psbp_pkg::ST_HEAD && queue_rd.valid && !halted_ff &&
                     (head.want_ref || head.kind == psbp_pkg::CMD_EVENT));
   end

   always_comb begin
      state_in      = state_ff;
      phase_ref_in  = phase_ref_ff;
      open_banks_in = open_banks_ff;
      fill_in       = fill_ff;
      halted_in     = halted_ff;
      emit          = 1'b0;
      res           = '0;
      pop           = 1'b0;
      if (out_free) begin
         case (state_ff)
            psbp_pkg::ST_HEAD: begin
               if (queue_rd.valid && halted_ff) begin
                  emit = 1'b1;
                  res  = status_res(open_banks_ff, psbp_pkg::STATUS_HALTED);
                  pop  = 1'b1;
               end else if (queue_rd.valid && !head.want_ref &&
                            head.kind == psbp_pkg::CMD_FAIL) begin
                  emit      = 1'b1;
                  res       = status_res(open_banks_ff, psbp_pkg::STATUS_MID_EVENT);
                  halted_in = 1'b1;
                  pop       = 1'b1;
               end else if (queue_rd.valid && !head.want_ref &&
                            head.kind == psbp_pkg::CMD_NONE) begin
                  pop = 1'b1;
               end
            end
            psbp_pkg::ST_ROOM: begin
               state_in = psbp_pkg::ST_ROOM;
            end
            psbp_pkg::ST_BYTE1: begin
               emit     = 1'b1;
               res      = write_res(open_banks_ff, fill_ff, head.byte1);
               res.last = 1'b1;
               fill_in  = fill_ff + 1'b1;
               pop      = 1'b1;
               state_in = psbp_pkg::ST_HEAD;
            end
            psbp_pkg::ST_JUMP1: begin
               emit     = 1'b1;
               res      = write_res(open_banks_ff, fill_ff,
                                    psbp_pkg::JUMP_TARGET[psbp_pkg::BYTE_W-1:0]);
               fill_in  = fill_ff + 1'b1;
               state_in = psbp_pkg::ST_JUMP2;
            end
            psbp_pkg::ST_JUMP2: begin
               emit     = 1'b1;
               res      = write_res(open_banks_ff, fill_ff,
                                    psbp_pkg::JUMP_TARGET[psbp_pkg::ADDR_W-1:psbp_pkg::BYTE_W]);
               fill_in  = psbp_pkg::HOLE_END;
               state_in = psbp_pkg::ST_ROOM;
            end
            psbp_pkg::ST_CONT1: begin
               emit          = 1'b1;
               res           = write_res(open_banks_ff, fill_ff,
                                         psbp_pkg::BYTE_W'(open_banks_ff + 1'b1));
               open_banks_in = open_banks_ff + 1'b1;
               fill_in       = '0;
               state_in      = psbp_pkg::ST_ROOM;
            end
            psbp_pkg::ST_FAIL: begin
               emit      = 1'b1;
               res       = status_res(open_banks_ff, psbp_pkg::STATUS_MID_EVENT);
               halted_in = 1'b1;
               pop       = 1'b1;
               state_in  = psbp_pkg::ST_HEAD;
            end
            default: begin
               state_in = psbp_pkg::ST_HEAD;
            end
         endcase

         if (room_active) begin
            open_banks_in = ob_eff;
            phase_ref_in  = room_ref;
            emit          = 1'b1;
            if (jump_need) begin
               res      = write_res(ob_eff, f_eff, psbp_pkg::MARK_JUMP);
               fill_in  = f_eff + 1'b1;
               state_in = psbp_pkg::ST_JUMP1;
            end else if (cont_need && no_bank) begin
               res       = status_res(ob_eff, psbp_pkg::STATUS_OUT_OF_BANKS);
               halted_in = 1'b1;
               pop       = 1'b1;
               state_in  = psbp_pkg::ST_HEAD;
            end else if (cont_need) begin
               res      = write_res(ob_eff, f_eff, psbp_pkg::MARK_CONTINUE);
               fill_in  = f_eff + 1'b1;
               state_in = psbp_pkg::ST_CONT1;
            end else if (room_ref) begin
               res                 = '0;
               res.ref_valid       = 1'b1;
               res.ref_bank_number = ob_eff;
               res.ref_window_addr = psbp_pkg::WINDOW_BASE +
                                     {{(psbp_pkg::ADDR_W - psbp_pkg::FILL_W){1'b0}}, f_eff};
               res.banks_used      = ob_eff;
               res.status          = psbp_pkg::STATUS_OK;
               res.last            = head.kind == psbp_pkg::CMD_NONE;
               fill_in             = f_eff;
               case (head.kind)
                  psbp_pkg::CMD_EVENT: begin
                     phase_ref_in = 1'b0;
                     state_in     = psbp_pkg::ST_ROOM;
                  end
                  psbp_pkg::CMD_FAIL: begin
                     state_in = psbp_pkg::ST_FAIL;
                  end
                  default: begin
                     pop      = 1'b1;
                     state_in = psbp_pkg::ST_HEAD;
                  end
               endcase
            end else begin
               res      = write_res(ob_eff, f_eff, head.byte0);
               res.last = !head.two_byte;
               fill_in  = f_eff + 1'b1;
               if (head.two_byte) begin
                  state_in = psbp_pkg::ST_BYTE1;
               end else begin
                  pop      = 1'b1;
                  state_in = psbp_pkg::ST_HEAD;
               end
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= psbp_pkg::ST_HEAD;
         phase_ref_ff  <= 1'b0;
         open_banks_ff <= '0;
         fill_ff       <= '0;
         halted_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ref_ff  <= phase_ref_in;
         open_banks_ff <= open_banks_in;
         fill_ff       <= fill_in;
         halted_ff     <= halted_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.write_valid     = rsp_ff.write_valid;
   assign rsp_ch.bank_index      = rsp_ff.bank_index;
   assign rsp_ch.byte_offset     = rsp_ff.byte_offset;
   assign rsp_ch.byte_value      = rsp_ff.byte_value;
   assign rsp_ch.ref_valid       = rsp_ff.ref_valid;
   assign rsp_ch.ref_bank_number = rsp_ff.ref_bank_number;
   assign rsp_ch.ref_window_addr = rsp_ff.ref_window_addr;
   assign rsp_ch.banks_used      = rsp_ff.banks_used;
   assign rsp_ch.status          = rsp_ff.status;
   assign rsp_ch.last            = rsp_ff.last;

endmodule
`default_nettype wire

/* rtl/core/paged_stream_bank_packer_core.sv */
// Top level of the paged stream bank packer: front end, command queue and placement engine.
//
//   Port     Direction  Carries
//   req_ch   sink       one stream byte with first and last of track flags
//   rsp_ch   source     one bank write, track reference or status per transfer
//
// The front end takes one byte per cycle while the four-entry command queue has room.
// The placement engine spends one cycle per result while its result register can take it.
// A jump marker is followed by its target address, a continue marker by the next bank number.
// Synchronous reset empties the queue, closes all banks and clears the halt.
// A stalled result register holds the engine, and a full queue holds the input.
`timescale 1ns / 1ps
`default_nettype none
module paged_stream_bank_packer_core #(
   parameter int BANK_BYTES     = 8192,
   parameter int MAX_BANK_COUNT = 127
) (
   input  wire logic  clock,
   input  wire logic  reset,
   psbp_req_if.sink   req_ch,
   psbp_rsp_if.source rsp_ch
);

   psbp_pkg::queue_wr_type queue_wr;
   psbp_pkg::queue_rd_type queue_rd;
   logic                   pop;

   psbp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .queue_rd (queue_rd),
      .queue_wr (queue_wr)
   );

   psbp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .queue_wr (queue_wr),
      .pop      (pop),
      .queue_rd (queue_rd)
   );

   psbp_back #(
      .BANK_BYTES     (BANK_BYTES),
      .MAX_BANK_COUNT (MAX_BANK_COUNT)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .queue_rd (queue_rd),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule
`default_nettype wire

/* tb/sv/paged_stream_bank_packer_core_check.sv */
// Checker that predicts the bank packer's results from observed input transfers and compares them.
`timescale 1ns / 1ps
module paged_stream_bank_packer_core_check #(
   parameter int BANK_BYTES     = 8192,
   parameter int MAX_BANK_COUNT = 127
) (
   input  logic clock,
   input  logic reset,
   psbp_req_if  req_ch,
   psbp_rsp_if  rsp_ch,
   output int   results_due,
   output int   failures
);

   localparam int BANK_LIMIT = (MAX_BANK_COUNT > psbp_pkg::BANK_CAP) ?
                               psbp_pkg::BANK_CAP : MAX_BANK_COUNT;

   logic [psbp_pkg::BANK_W-1:0] banks_open;
   logic [psbp_pkg::FILL_W-1:0] fill_pos;
   logic                        held_valid;
   logic [psbp_pkg::BYTE_W-1:0] held_byte;
   logic                        stopped;

   psbp_pkg::result_type bank_results_due[$];
   int                   mismatch_count = 0;
   int                   step_base;

   assign failures = mismatch_count;

   function automatic string describe(psbp_pkg::result_type r);
      return $sformatf({"wr=%0d bank=%0d off=%h val=%h ref=%0d rbank=%0d raddr=%h ",
                        "used=%0d status=%0d last=%0d"},
                       r.write_valid, r.bank_index, r.byte_offset, r.byte_value, r.ref_valid,
                       r.ref_bank_number, r.ref_window_addr, r.banks_used, r.status, r.last);
   endfunction

   function automatic void post(logic wv, logic [psbp_pkg::BANK_W-1:0] bank,
                                logic [psbp_pkg::FILL_W-1:0] off,
                                logic [psbp_pkg::BYTE_W-1:0] val, logic rv,
                                logic [psbp_pkg::BANK_W-1:0] rbank,
                                logic [psbp_pkg::ADDR_W-1:0] raddr,
                                psbp_pkg::status_type st);
      psbp_pkg::result_type r;
      r.write_valid     = wv;
      r.bank_index      = bank;
      r.byte_offset     = off[psbp_pkg::OFFSET_W-1:0];
      r.byte_value      = val;
      r.ref_valid       = rv;
      r.ref_bank_number = rbank;
      r.ref_window_addr = raddr;
      r.banks_used      = banks_open;
      r.status          = st;
      r.last            = 1'b0;
      bank_results_due.push_back(r);
   endfunction

   function automatic void write_byte(logic [psbp_pkg::BYTE_W-1:0] val);
      post(1'b1, banks_open - 1'b1, fill_pos, val, 1'b0, '0, '0, psbp_pkg::STATUS_OK);
      fill_pos = fill_pos + 1'b1;
   endfunction

   function automatic void close_step();
      if (bank_results_due.size() > step_base) begin
         bank_results_due[bank_results_due.size() - 1].last = 1'b1;
      end
   endfunction

   function automatic void halt_with(psbp_pkg::status_type st);
      stopped    = 1'b1;
      held_valid = 1'b0;
      post(1'b0, '0, '0, '0, 1'b0, '0, '0, st);
      close_step();
   endfunction

   // Returns 1 when a new bank is needed but none is left.
   function automatic bit reserve_space(int size);
      int f;
      if (banks_open == 0) begin
         if (BANK_LIMIT == 0) begin
            return 1'b1;
         end
         banks_open = 1;
         fill_pos   = '0;
      end
      for (int guard = 0; guard < 8; guard++) begin
         f = int'(fill_pos);
         if (f >= int'(psbp_pkg::HOLE_START) && f < int'(psbp_pkg::HOLE_END)) begin
            fill_pos = psbp_pkg::HOLE_END;
            continue;
         end
         if (f < int'(psbp_pkg::HOLE_START) && f + size > int'(psbp_pkg::HOLE_START) - 3) begin
            write_byte(psbp_pkg::MARK_JUMP);
            write_byte(psbp_pkg::JUMP_TARGET[7:0]);
            write_byte(psbp_pkg::JUMP_TARGET[15:8]);
            fill_pos = psbp_pkg::HOLE_END;
            continue;
         end
         if (f + size > BANK_BYTES - 2) begin
            if (int'(banks_open) >= BANK_LIMIT) begin
               return 1'b1;
            end
            write_byte(psbp_pkg::BYTE_W'(banks_open + 1'b1));
            banks_open = banks_open + 1'b1;
            fill_pos   = '0;
            continue;
         end
         return 1'b0;
      end
      return 1'b0;
   endfunction

   function automatic void place_stream_byte(logic [psbp_pkg::BYTE_W-1:0] b, logic first,
                                             logic lastb);
      logic [psbp_pkg::BYTE_W-1:0] ev0;
      logic [psbp_pkg::BYTE_W-1:0] ev1;
      int                          size;
      step_base = bank_results_due.size();
      if (stopped) begin
         post(1'b0, '0, '0, '0, 1'b0, '0, '0, psbp_pkg::STATUS_HALTED);
         close_step();
         return;
      end
      if (first) begin
         if (held_valid) begin
            halt_with(psbp_pkg::STATUS_MID_EVENT);
            return;
         end
         if (reserve_space(1)) begin
            halt_with(psbp_pkg::STATUS_OUT_OF_BANKS);
            return;
         end
         post(1'b0, '0, '0, '0, 1'b1, banks_open,
              psbp_pkg::WINDOW_BASE + {2'b00, fill_pos}, psbp_pkg::STATUS_OK);
      end
      if (held_valid) begin
         ev0        = held_byte;
         ev1        = b;
         size       = 2;
         held_valid = 1'b0;
      end else if (b >= psbp_pkg::SHORT_EVENT_MIN) begin
         ev0  = b;
         ev1  = '0;
         size = 1;
      end else begin
         if (lastb) begin
            halt_with(psbp_pkg::STATUS_MID_EVENT);
            return;
         end
         held_valid = 1'b1;
         held_byte  = b;
         close_step();
         return;
      end
      if (reserve_space(size)) begin
         halt_with(psbp_pkg::STATUS_OUT_OF_BANKS);
         return;
      end
      write_byte(ev0);
      if (size == 2) begin
         write_byte(ev1);
      end
      close_step();
   endfunction

   always @(posedge clock) begin : watch
      psbp_pkg::result_type seen;
      psbp_pkg::result_type want;
      if (reset) begin
         banks_open = '0;
         fill_pos   = '0;
         held_valid = 1'b0;
         held_byte  = '0;
         stopped    = 1'b0;
         bank_results_due.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            place_stream_byte(req_ch.stream_byte, req_ch.first_of_track, req_ch.last_of_track);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.write_valid     = rsp_ch.write_valid;
            seen.bank_index      = rsp_ch.bank_index;
            seen.byte_offset     = rsp_ch.byte_offset;
            seen.byte_value      = rsp_ch.byte_value;
            seen.ref_valid       = rsp_ch.ref_valid;
            seen.ref_bank_number = rsp_ch.ref_bank_number;
            seen.ref_window_addr = rsp_ch.ref_window_addr;
            seen.banks_used      = rsp_ch.banks_used;
            seen.status          = psbp_pkg::status_type'(rsp_ch.status);
            seen.last            = rsp_ch.last;
            if (bank_results_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: result transfer with nothing expected: %s", $realtime,
                           describe(seen));
               end
            end else begin
               want = bank_results_due.pop_front();
               if (seen !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: result mismatch\n  expected %s\n  actual   %s", $realtime,
                              describe(want), describe(seen));
                  end
               end
            end
         end
      end
      results_due <= bank_results_due.size();
   end

endmodule

/* tb/sv/paged_stream_bank_packer_core_tb.sv */
// Top of the bank packer testbench: clock, reset, stimulus, handshake pressure and verdict.
`timescale 1ns / 1ps
module paged_stream_bank_packer_core_tb;

   localparam int BANK_BYTES  = 8192;
   localparam int BANK_QUOTA  = 2;
   localparam int CYCLE_LIMIT = 100000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        calm  = 1'b0;
   int          results_due;
   int          failures;
   int unsigned cycle_count = 0;

   psbp_req_if req_ch ();
   psbp_rsp_if rsp_ch ();

   paged_stream_bank_packer_core #(
      .BANK_BYTES     (BANK_BYTES),
      .MAX_BANK_COUNT (BANK_QUOTA)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   paged_stream_bank_packer_core_check #(
      .BANK_BYTES     (BANK_BYTES),
      .MAX_BANK_COUNT (BANK_QUOTA)
   ) u_check (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .results_due (results_due),
      .failures    (failures)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 25);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_byte(input logic [psbp_pkg::BYTE_W-1:0] b, input logic first,
                            input logic lastb);
      while (!calm && $urandom_range(99) < 25) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.stream_byte    <= b;
      req_ch.first_of_track <= first;
      req_ch.last_of_track  <= lastb;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
   endtask

   // Sends one well-formed event with random content and random track flags.
   task automatic send_event(output int n);
      logic [psbp_pkg::BYTE_W-1:0] lead;
      logic [psbp_pkg::BYTE_W-1:0] tail;
      logic                        first;
      logic                        lastb;
      first = ($urandom_range(99) < 12);
      lastb = ($urandom_range(99) < 8);
      if ($urandom_range(99) < 20) begin
         lead = psbp_pkg::SHORT_EVENT_MIN | psbp_pkg::BYTE_W'($urandom_range(1));
         send_byte(lead, first, lastb);
         n = 1;
      end else begin
         lead = psbp_pkg::BYTE_W'($urandom_range(int'(psbp_pkg::SHORT_EVENT_MIN) - 1));
         tail = psbp_pkg::BYTE_W'($urandom_range(255));
         send_byte(lead, first, 1'b0);
         send_byte(tail, 1'b0, lastb);
         n = 2;
      end
   endtask

   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      int sent;
      int n;
      req_ch.valid          <= 1'b0;
      req_ch.stream_byte    <= '0;
      req_ch.first_of_track <= 1'b0;
      req_ch.last_of_track  <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // The first byte of the run opens bank zero and reports a track reference.
      send_byte(8'hFE, 1'b1, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b1);
      send_byte(psbp_pkg::MARK_CONTINUE, 1'b1, 1'b0);
      send_byte(psbp_pkg::MARK_JUMP, 1'b0, 1'b0);
      send_byte(8'hFE, 1'b1, 1'b1);
      send_byte(8'h7F, 1'b0, 1'b0);
      send_byte(8'h80, 1'b0, 1'b1);
      send_byte(8'hAA, 1'b1, 1'b0);
      send_byte(8'h55, 1'b0, 1'b1);
      send_byte(8'hFC, 1'b0, 1'b0);
      send_byte(8'hFE, 1'b0, 1'b0);
      send_byte(8'h01, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b1, 1'b1);
      send_byte(8'hFD, 1'b0, 1'b0);
      send_byte(8'hFD, 1'b0, 1'b0);
      hold_until_drained();

      sent = 0;
      while (sent < 396) begin
         if (sent >= 130 && sent < 280) begin
            calm <= 1'b1;
         end else begin
            calm <= 1'b0;
         end
         send_event(n);
         sent += n;
         if ($urandom_range(99) == 0) begin
            hold_until_drained();
         end
      end

      case ($urandom_range(2))
         0: send_byte(psbp_pkg::BYTE_W'($urandom_range(int'(psbp_pkg::SHORT_EVENT_MIN) - 1)),
                      1'($urandom_range(1)), 1'b1);
         1: begin
            send_byte(psbp_pkg::BYTE_W'($urandom_range(int'(psbp_pkg::SHORT_EVENT_MIN) - 1)),
                      1'($urandom_range(1)), 1'b0);
            send_byte(psbp_pkg::BYTE_W'($urandom_range(255)), 1'b1, 1'($urandom_range(1)));
         end
         default: begin
            while (sent < 400) begin
               send_event(n);
               sent += n;
            end
         end
      endcase

      repeat (10) begin
         send_byte(psbp_pkg::BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
      end

      hold_until_drained();
      repeat (64) @(posedge clock);
      if (failures == 0 && results_due == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/psbp_pkg.sv
rtl/core/psbp_req_if.sv
rtl/core/psbp_rsp_if.sv
rtl/core/psbp_front.sv
rtl/core/psbp_queue.sv
rtl/core/psbp_back.sv
rtl/core/paged_stream_bank_packer_core.sv
tb/sv/paged_stream_bank_packer_core_check.sv
tb/sv/paged_stream_bank_packer_core_tb.sv
